@@ hdl/stack_language_tokenizer_assert.svh @@
// Assertion macros, compiled out for synthesis.
`ifndef STACK_LANGUAGE_TOKENIZER_ASSERT_SVH
`define STACK_LANGUAGE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slt: same-cycle check failed");
`define SLT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slt: next-cycle check failed");
`else
`define SLT_ASSERT_IMP(lbl, ante, cons)
`define SLT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/slt_pkg.sv @@
`default_nettype none
package slt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_SIG     = 3'd2,
		MODE_AFTER   = 3'd3,
		MODE_NUMBER  = 3'd4,
		MODE_WORD    = 3'd5,
		MODE_ENDED   = 3'd6
	} mode_t;

	typedef logic [2:0] kind_t;

	localparam kind_t K_EOL    = 3'd0;
	localparam kind_t K_BDEF   = 3'd1;
	localparam kind_t K_EDEF   = 3'd2;
	localparam kind_t K_BQUOTE = 3'd3;
	localparam kind_t K_EQUOTE = 3'd4;
	localparam kind_t K_NUMBER = 3'd5;
	localparam kind_t K_WORD   = 3'd6;
	localparam kind_t K_END    = 3'd7;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_E      = 8'h65;

	typedef struct packed {
		kind_t      token_kind;
		logic [7:0] text_char;
		logic       has_char;
		logic       token_done;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		mode_t       nxt_mode;
		logic [1:0]  n_res;
		res_t        r0;
		res_t        r1;
	} dec_t;

endpackage
`default_nettype wire

@@ hdl/slt_if.sv @@
`default_nettype none
interface slt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] input_char;
	logic       end_of_input;

	modport source (output valid, input_char, end_of_input, input ready);
	modport sink (input valid, input_char, end_of_input, output ready);
endinterface

interface slt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] text_char;
	logic       has_char;
	logic       token_done;
	logic       last_of_run;

	modport source (output valid, token_kind, text_char, has_char, token_done, last_of_run,
		input ready);
	modport sink (input valid, token_kind, text_char, has_char, token_done, last_of_run,
		output ready);
endinterface
`default_nettype wire

@@ hdl/slt_decode.sv @@
`default_nettype none
module slt_decode #(
	parameter int DEPTH_WIDTH = 8
) (
	input  wire slt_pkg::mode_t           mode,
	input  wire logic [DEPTH_WIDTH-1:0]   depth,
	input  wire logic [7:0]               c,
	input  wire logic                     eoi,
	output slt_pkg::dec_t                 dec,
	output logic [DEPTH_WIDTH-1:0]        nxt_depth
);

	localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = {{(DEPTH_WIDTH-1){1'b0}}, 1'b1};

	function automatic slt_pkg::res_t mk(slt_pkg::kind_t k, logic [7:0] ch, logic has);
		slt_pkg::res_t r;
		r.token_kind  = k;
		r.text_char   = has ? ch : 8'h00;
		r.has_char    = has;
		r.token_done  = !has;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	logic            is_digit, is_blank, is_nl, is_delim, num_cont, word_cont;
	slt_pkg::res_t   idle_res;
	logic            idle_has, idle_set;
	slt_pkg::mode_t  idle_mode;
	logic [DEPTH_WIDTH-1:0] dep_dec;

	assign is_digit = (c >= slt_pkg::CH_ZERO) && (c <= slt_pkg::CH_NINE);
	assign is_blank = (c == slt_pkg::CH_SPACE) || (c == slt_pkg::CH_TAB) ||
		(c == slt_pkg::CH_VT) || (c == slt_pkg::CH_FF);
	assign is_nl    = (c == slt_pkg::CH_LF) || (c == slt_pkg::CH_CR);
	assign is_delim = (c == slt_pkg::CH_HASH) || (c == slt_pkg::CH_LPAREN) ||
		(c == slt_pkg::CH_RPAREN) || (c == slt_pkg::CH_COLON) ||
		(c == slt_pkg::CH_SEMI) || (c == slt_pkg::CH_LBRACK) ||
		(c == slt_pkg::CH_RBRACK);
	assign num_cont  = !eoi && (is_digit || c == slt_pkg::CH_DOT || c == slt_pkg::CH_E);
	assign word_cont = !eoi && c != slt_pkg::CH_NUL && !is_blank && !is_nl && !is_delim;
	assign dep_dec   = (depth != '0) ? depth - DEPTH_ONE : '0;

	always_comb begin
		idle_res  = mk(slt_pkg::K_EOL, c, 1'b0);
		idle_has  = 1'b0;
		idle_set  = 1'b0;
		idle_mode = slt_pkg::MODE_IDLE;
		priority if (eoi || c == slt_pkg::CH_NUL) begin
			idle_res  = mk(slt_pkg::K_END, c, 1'b0);
			idle_has  = 1'b1;
			idle_mode = slt_pkg::MODE_ENDED;
		end else if (is_nl) begin
			idle_has = 1'b1;
		end else if (is_blank || c == slt_pkg::CH_RPAREN) begin
			idle_has = 1'b0;
		end else if (c == slt_pkg::CH_HASH) begin
			idle_mode = slt_pkg::MODE_COMMENT;
		end else if (c == slt_pkg::CH_LPAREN) begin
			idle_mode = slt_pkg::MODE_SIG;
			idle_set  = 1'b1;
		end else if (c == slt_pkg::CH_COLON) begin
			idle_res = mk(slt_pkg::K_BDEF, c, 1'b0);
			idle_has = 1'b1;
		end else if (c == slt_pkg::CH_SEMI) begin
			idle_res = mk(slt_pkg::K_EDEF, c, 1'b0);
			idle_has = 1'b1;
		end else if (c == slt_pkg::CH_LBRACK) begin
			idle_res = mk(slt_pkg::K_BQUOTE, c, 1'b0);
			idle_has = 1'b1;
		end else if (c == slt_pkg::CH_RBRACK) begin
			idle_res = mk(slt_pkg::K_EQUOTE, c, 1'b0);
			idle_has = 1'b1;
		end else if (is_digit) begin
			idle_res  = mk(slt_pkg::K_NUMBER, c, 1'b1);
			idle_has  = 1'b1;
			idle_mode = slt_pkg::MODE_NUMBER;
		end else begin
			idle_res  = mk(slt_pkg::K_WORD, c, 1'b1);
			idle_has  = 1'b1;
			idle_mode = slt_pkg::MODE_WORD;
		end
	end

	always_comb begin
		dec.nxt_mode = mode;
		dec.n_res    = 2'd0;
		dec.r0       = idle_res;
		dec.r1       = idle_res;
		nxt_depth    = depth;
		unique case (mode)
			slt_pkg::MODE_COMMENT: begin
				if (eoi) begin
					dec.r0       = mk(slt_pkg::K_END, c, 1'b0);
					dec.n_res    = 2'd1;
					dec.nxt_mode = slt_pkg::MODE_ENDED;
				end else if (is_nl) begin
					dec.nxt_mode = slt_pkg::MODE_IDLE;
				end
			end
			slt_pkg::MODE_SIG: begin
				if (eoi) begin
					dec.r0       = mk(slt_pkg::K_END, c, 1'b0);
					dec.n_res    = 2'd1;
					dec.nxt_mode = slt_pkg::MODE_ENDED;
				end else if (c == slt_pkg::CH_LPAREN) begin
					if (depth != DEPTH_MAX) nxt_depth = depth + DEPTH_ONE;
				end else if (c == slt_pkg::CH_RPAREN) begin
					nxt_depth = dep_dec;
					if (dep_dec == '0) dec.nxt_mode = slt_pkg::MODE_AFTER;
				end
			end
			slt_pkg::MODE_AFTER: begin
				if (eoi) begin
					dec.r0       = mk(slt_pkg::K_END, c, 1'b0);
					dec.n_res    = 2'd1;
					dec.nxt_mode = slt_pkg::MODE_ENDED;
				end else begin
					dec.nxt_mode = slt_pkg::MODE_IDLE;
				end
			end
			slt_pkg::MODE_NUMBER: begin
				if (num_cont) begin
					dec.r0    = mk(slt_pkg::K_NUMBER, c, 1'b1);
					dec.n_res = 2'd1;
				end else begin
					dec.r0       = mk(slt_pkg::K_NUMBER, c, 1'b0);
					dec.n_res    = idle_has ? 2'd2 : 2'd1;
					dec.nxt_mode = idle_mode;
					if (idle_set) nxt_depth = DEPTH_ONE;
				end
			end
			slt_pkg::MODE_WORD: begin
				if (word_cont) begin
					dec.r0    = mk(slt_pkg::K_WORD, c, 1'b1);
					dec.n_res = 2'd1;
				end else begin
					dec.r0       = mk(slt_pkg::K_WORD, c, 1'b0);
					dec.n_res    = idle_has ? 2'd2 : 2'd1;
					dec.nxt_mode = idle_mode;
					if (idle_set) nxt_depth = DEPTH_ONE;
				end
			end
			slt_pkg::MODE_ENDED: begin
				dec.r0    = mk(slt_pkg::K_END, c, 1'b0);
				dec.n_res = 2'd1;
			end
			default: begin
				dec.r0       = idle_res;
				dec.n_res    = {1'b0, idle_has};
				dec.nxt_mode = idle_mode;
				if (idle_set) nxt_depth = DEPTH_ONE;
			end
		endcase
		if (dec.n_res == 2'd1) dec.r0.last_of_run = 1'b1;
		if (dec.n_res == 2'd2) dec.r1.last_of_run = 1'b1;
	end

endmodule
`default_nettype wire

@@ hdl/slt_outq.sv @@
`default_nettype none
module slt_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [1:0]    push_n,
	input  wire slt_pkg::res_t r0,
	input  wire slt_pkg::res_t r1,
	input  wire logic          pop,
	output logic               room,
	output logic               valid,
	output slt_pkg::res_t      head
);

	localparam int QDEPTH = 4;
	localparam int PW     = $clog2(QDEPTH);

	slt_pkg::res_t  mem_q [QDEPTH];
	logic [PW-1:0]  head_q, tail_q;
	logic [PW:0]    cnt_q;
	logic [1:0]     pn;

	assign pn    = push ? push_n : 2'd0;
	assign room  = cnt_q <= (PW+1)'(QDEPTH - 2);
	assign valid = cnt_q != '0;
	assign head  = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (pn != 2'd0) mem_q[tail_q] <= r0;
		if (pn == 2'd2) mem_q[tail_q + PW'(1)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + PW'(pn);
			if (pop) head_q <= head_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(pn) - (PW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

@@ hdl/stack_language_tokenizer.sv @@
// A character accepted on the input is held in the input stage register and
// decoded there; its tokens are written into the result queue that drives the
// token port. Throughput: one character per cycle while the queue has room; a
// character that yields two tokens takes two entries of the 4-word result queue.
// Reset (arst_n low): scan mode idle, nesting depth zero, input stage and
// result queue empty.
`default_nettype none
`include "stack_language_tokenizer_assert.svh"
module stack_language_tokenizer #(
	parameter int DEPTH_WIDTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slt_in_if.sink     chars,
	slt_out_if.source  tokens
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   eoi_s1;
	slt_pkg::mode_t         mode_q;
	logic [DEPTH_WIDTH-1:0] depth_q;

	slt_pkg::dec_t          dec;
	logic [DEPTH_WIDTH-1:0] nxt_depth;
	logic                   room, adv, take;
	slt_pkg::res_t          head;

	assign adv         = valid_s1 && room;
	assign chars.ready = !valid_s1 || room;
	assign take        = chars.valid && chars.ready;

	slt_decode #(.DEPTH_WIDTH(DEPTH_WIDTH)) u_dec (
		.mode      (mode_q),
		.depth     (depth_q),
		.c         (char_s1),
		.eoi       (eoi_s1),
		.dec       (dec),
		.nxt_depth (nxt_depth)
	);

	slt_outq u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.push_n (dec.n_res),
		.r0     (dec.r0),
		.r1     (dec.r1),
		.pop    (tokens.valid && tokens.ready),
		.room   (room),
		.valid  (tokens.valid),
		.head   (head)
	);

	assign tokens.token_kind  = head.token_kind;
	assign tokens.text_char   = head.text_char;
	assign tokens.has_char    = head.has_char;
	assign tokens.token_done  = head.token_done;
	assign tokens.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= chars.input_char;
			eoi_s1  <= chars.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= slt_pkg::MODE_IDLE;
			depth_q  <= '0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				mode_q  <= dec.nxt_mode;
				depth_q <= nxt_depth;
			end
		end
	end

	`SLT_ASSERT_NXT(a_ended_sticky, mode_q == slt_pkg::MODE_ENDED, mode_q == slt_pkg::MODE_ENDED)
	`SLT_ASSERT_NXT(a_eoi_ends, adv && eoi_s1, mode_q == slt_pkg::MODE_ENDED)
	`SLT_ASSERT_IMP(a_sig_depth, mode_q == slt_pkg::MODE_SIG, depth_q != '0)

endmodule
`default_nettype wire
